// ===== design/four_register_cpu_execute_macros.svh =====
// ============================================================================
// Four-register CPU execute: assertion macros
// Shared property forms used by the port checker of the execute block.
// ============================================================================
`ifndef FOUR_REGISTER_CPU_EXECUTE_MACROS_SVH
`define FOUR_REGISTER_CPU_EXECUTE_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define FRCPU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define FRCPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define FRCPU_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/frcpu_pkg.sv =====
// ============================================================================
// Four-register CPU execute: shared package
// Widths, function codes, decoded operation types and beat layouts.
// ============================================================================
`timescale 1ns / 1ps

package frcpu_pkg;

  // Architectural sizes.
  localparam int PC_W          = 10;
  localparam int PROGRAM_DEPTH = 1 << PC_W;
  localparam int WORD_W        = 16;
  localparam int REG_AW        = 2;
  localparam int NUM_REGS      = 1 << REG_AW;
  localparam int DATA_AW       = 8;
  localparam int DATA_DEPTH    = 1 << DATA_AW;
  localparam int LEN_W         = PC_W + 1;
  localparam int FUNC_W        = 4;

  // Beat layouts.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // Decoupling queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Function codes as they arrive on the input.
  localparam logic [FUNC_W-1:0] FN_LDI     = 4'd0;
  localparam logic [FUNC_W-1:0] FN_LD      = 4'd1;
  localparam logic [FUNC_W-1:0] FN_ST      = 4'd2;
  localparam logic [FUNC_W-1:0] FN_JZ      = 4'd3;
  localparam logic [FUNC_W-1:0] FN_JMP     = 4'd4;
  localparam logic [FUNC_W-1:0] FN_ADD     = 4'd5;
  localparam logic [FUNC_W-1:0] FN_SUB     = 4'd6;
  localparam logic [FUNC_W-1:0] FN_AND     = 4'd7;
  localparam logic [FUNC_W-1:0] FN_OR      = 4'd8;
  localparam logic [FUNC_W-1:0] FN_XOR     = 4'd9;
  localparam logic [FUNC_W-1:0] FN_NOT     = 4'd10;
  localparam logic [FUNC_W-1:0] FN_MOV     = 4'd11;
  localparam logic [FUNC_W-1:0] FN_INC     = 4'd12;
  localparam logic [FUNC_W-1:0] FN_DEC     = 4'd13;
  localparam logic [FUNC_W-1:0] FN_PRELOAD = 4'd14;

  // Operation class found by the front part.
  typedef enum logic [2:0] {
    OP_LDI,
    OP_LD,
    OP_ST,
    OP_JZ,
    OP_JMP,
    OP_ALU,
    OP_PRELOAD,
    OP_NOP
  } kind_t;

  // ALU function for register-writing arithmetic and logic operations.
  typedef enum logic [3:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_XOR,
    ALU_NOT,
    ALU_MOV,
    ALU_INC,
    ALU_DEC
  } alu_t;

  // Decoded operation as it waits in the queue.
  // rb is the second register-file read port: src_b for two-operand
  // ALU operations, otherwise first_reg (store data, inc and dec).
  typedef struct packed {
    kind_t                   kind;
    alu_t                    alu;
    logic [REG_AW-1:0]       rd;
    logic [REG_AW-1:0]       ra;
    logic [REG_AW-1:0]       rb;
    logic [WORD_W-1:0]       imm;
    logic [PC_W-1:0]         target;
    logic [DATA_AW-1:0]      paddr;
  } uop_t;

  // Queue status seen by the front part.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== design/four_register_cpu_execute.sv =====
// ============================================================================
// Four-register CPU execute: top level
// Executes one decoded instruction per beat of a four-register machine with
// a zero flag, a program counter and a word-addressed data memory.
// ============================================================================
//
// Channel    Direction  Handshake            Payload
// s_*        in         s_tvalid/s_tready    decoded instruction, func on tuser
// m_*        out        m_tvalid/m_tready    result of one instruction
// cfg_*      in         cfg_wr_en            program_length
//
// Most instructions finish in the execute stage directly; ld also passes
// through ST_LOAD for the registered read of the data memory.
// A beat is written into the queue, then loaded into the execute stage,
// and its result is registered onto m_* when the stage finishes.
// Reset clears the registers, the zero flag, the program counter, the
// program length and the written marks of the data memory.
// A two-entry queue keeps taking beats, until it is full, while a result waits on m_tready.
//
`timescale 1ns / 1ps

module four_register_cpu_execute (
  input  logic                             clk,
  input  logic                             rst,
  // Input: first_reg, src_a_reg, src_b_reg, immediate, jump_target,
  // preload_address (from bit 0 up).
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [frcpu_pkg::IN_DATA_W-1:0]  s_tdata,
  // func
  input  logic [frcpu_pkg::FUNC_W-1:0]     s_tuser,
  // Output: next_pc, reg_index, reg_value, zero_flag, zero padding.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [frcpu_pkg::OUT_DATA_W-1:0] m_tdata,
  // reg_write
  output logic                             m_tuser,
  // finished
  output logic                             m_tlast,
  input  logic                             cfg_wr_en,
  input  logic [frcpu_pkg::LEN_W-1:0]      cfg_wr_data
);
  import frcpu_pkg::*;

  logic [LEN_W-1:0]  program_length;
  logic              push;
  logic              pop;
  uop_t              push_uop;
  uop_t              head_uop;
  queue_status_t     q_status;

  // Program length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (cfg_wr_en) begin
      program_length <= cfg_wr_data;
    end
  end

  frcpu_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_status (q_status),
    .push     (push),
    .push_uop (push_uop)
  );

  frcpu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_uop (push_uop),
    .pop      (pop),
    .head_uop (head_uop),
    .status   (q_status)
  );

  frcpu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_status       (q_status),
    .head_uop       (head_uop),
    .pop            (pop),
    .program_length (program_length),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast)
  );

endmodule

// ===== design/frcpu_front.sv =====
// ============================================================================
// Four-register CPU execute: front part
// Accepts instruction beats, classifies them and pushes them into the queue.
// ============================================================================
`timescale 1ns / 1ps

module frcpu_front (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [frcpu_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic [frcpu_pkg::FUNC_W-1:0]    s_tuser,
  input  frcpu_pkg::queue_status_t       q_status,
  output logic                           push,
  output frcpu_pkg::uop_t                push_uop
);
  import frcpu_pkg::*;

  logic [REG_AW-1:0] first_reg;
  logic [REG_AW-1:0] src_a_reg;
  logic [REG_AW-1:0] src_b_reg;

  // Unpack the beat.
  assign first_reg = s_tdata[1:0];
  assign src_a_reg = s_tdata[3:2];
  assign src_b_reg = s_tdata[5:4];

  // A beat is taken whenever the queue has room.
  assign s_tready = !q_status.full;
  assign push     = s_tvalid && s_tready;

  // Classify the function code.
  always_comb begin
    push_uop        = '0;
    push_uop.kind   = OP_NOP;
    push_uop.alu    = ALU_MOV;
    push_uop.rd     = first_reg;
    push_uop.ra     = src_a_reg;
    push_uop.rb     = first_reg;
    push_uop.imm    = s_tdata[21:6];
    push_uop.target = s_tdata[31:22];
    push_uop.paddr  = s_tdata[39:32];
    unique case (s_tuser)
      FN_LDI:     push_uop.kind = OP_LDI;
      FN_LD:      push_uop.kind = OP_LD;
      FN_ST:      push_uop.kind = OP_ST;
      FN_JZ:      push_uop.kind = OP_JZ;
      FN_JMP:     push_uop.kind = OP_JMP;
      FN_ADD: begin
        push_uop.kind = OP_ALU;
        push_uop.alu  = ALU_ADD;
        push_uop.rb   = src_b_reg;
      end
      FN_SUB: begin
        push_uop.kind = OP_ALU;
        push_uop.alu  = ALU_SUB;
        push_uop.rb   = src_b_reg;
      end
      FN_AND: begin
        push_uop.kind = OP_ALU;
        push_uop.alu  = ALU_AND;
        push_uop.rb   = src_b_reg;
      end
      FN_OR: begin
        push_uop.kind = OP_ALU;
        push_uop.alu  = ALU_OR;
        push_uop.rb   = src_b_reg;
      end
      FN_XOR: begin
        push_uop.kind = OP_ALU;
        push_uop.alu  = ALU_XOR;
        push_uop.rb   = src_b_reg;
      end
      FN_NOT: begin
        push_uop.kind = OP_ALU;
        push_uop.alu  = ALU_NOT;
      end
      FN_MOV: begin
        push_uop.kind = OP_ALU;
        push_uop.alu  = ALU_MOV;
      end
      FN_INC: begin
        push_uop.kind = OP_ALU;
        push_uop.alu  = ALU_INC;
      end
      FN_DEC: begin
        push_uop.kind = OP_ALU;
        push_uop.alu  = ALU_DEC;
      end
      FN_PRELOAD: push_uop.kind = OP_PRELOAD;
      default:    push_uop.kind = OP_NOP;
    endcase
  end

endmodule

// ===== design/frcpu_queue.sv =====
// ============================================================================
// Four-register CPU execute: decoupling queue
// Short first-in first-out buffer of decoded operations.
// ============================================================================
`timescale 1ns / 1ps

module frcpu_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  frcpu_pkg::uop_t          push_uop,
  input  logic                     pop,
  output frcpu_pkg::uop_t          head_uop,
  output frcpu_pkg::queue_status_t status
);
  import frcpu_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  uop_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head_uop     = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_uop;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/frcpu_back.sv =====
// ============================================================================
// Four-register CPU execute: back part
// Reads operands, executes one operation, updates the machine state and
// holds the result beat until it is taken.
// ============================================================================
`timescale 1ns / 1ps

module frcpu_back (
  input  logic                            clk,
  input  logic                            rst,
  input  frcpu_pkg::queue_status_t        q_status,
  input  frcpu_pkg::uop_t                 head_uop,
  output logic                            pop,
  input  logic [frcpu_pkg::LEN_W-1:0]     program_length,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [frcpu_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tuser,
  output logic                            m_tlast
);
  import frcpu_pkg::*;

  typedef enum logic [1:0] {
    ST_EXEC = 2'b01,
    ST_LOAD = 2'b10
  } xstate_t;

  // Architectural state.
  logic [WORD_W-1:0]  rf [NUM_REGS];
  logic               zero_bit;
  logic [PC_W-1:0]    pc;
  logic [WORD_W-1:0]  mem [DATA_DEPTH];
  logic [DATA_DEPTH-1:0] mem_valid;

  // Execute stage.
  logic               x_valid;
  uop_t               x_uop;
  logic [WORD_W-1:0]  x_a;
  logic [WORD_W-1:0]  x_b;
  xstate_t            state;
  xstate_t            state_next;
  logic [WORD_W-1:0]  mem_rdata;
  logic               mem_rvalid;

  // Execute results.
  logic               out_free;
  logic               active;
  logic               ld_active;
  logic               x_done;
  logic               x_load;
  logic               mem_rd_en;
  logic [PC_W-1:0]    pc_next;
  logic               wr;
  logic               setz;
  logic [WORD_W-1:0]  val;
  logic               mem_we;
  logic [DATA_AW-1:0] mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic               zero_next;
  logic               finished;
  logic [WORD_W-1:0]  load_value;
  logic [WORD_W-1:0]  rd_a;
  logic [WORD_W-1:0]  rd_b;

  // Handshake and sequencing of the execute stage.
  assign out_free   = !m_tvalid || m_tready;
  assign active     = ({1'b0, pc} < program_length);
  assign ld_active  = x_valid && (x_uop.kind == OP_LD) && active;
  assign mem_rd_en  = ld_active && (state == ST_EXEC);
  assign x_done     = x_valid && out_free && (!ld_active || (state == ST_LOAD));
  assign x_load     = !q_status.empty && (!x_valid || x_done);
  assign pop        = x_load;
  assign load_value = mem_rvalid ? mem_rdata : '0;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_EXEC: if (mem_rd_en) state_next = ST_LOAD;
      ST_LOAD: if (x_done)    state_next = ST_EXEC;
      default:                state_next = ST_EXEC;
    endcase
  end

  // Execute the operation held in the stage.
  always_comb begin
    pc_next   = pc;
    wr        = 1'b0;
    setz      = 1'b0;
    val       = '0;
    mem_we    = 1'b0;
    mem_waddr = x_a[DATA_AW-1:0];
    mem_wdata = x_b;
    if (x_uop.kind == OP_PRELOAD) begin
      mem_we    = 1'b1;
      mem_waddr = x_uop.paddr;
      mem_wdata = x_uop.imm;
    end else if (x_uop.kind != OP_NOP && active) begin
      pc_next = pc + PC_W'(1);
      unique case (x_uop.kind)
        OP_LDI: begin
          wr  = 1'b1;
          val = x_uop.imm;
        end
        OP_LD: begin
          wr   = 1'b1;
          setz = 1'b1;
          val  = load_value;
        end
        OP_ST:  mem_we = 1'b1;
        OP_JZ:  if (zero_bit) pc_next = x_uop.target;
        OP_JMP: pc_next = x_uop.target;
        OP_ALU: begin
          wr   = 1'b1;
          setz = 1'b1;
          unique case (x_uop.alu)
            ALU_ADD: val = x_a + x_b;
            ALU_SUB: val = x_a - x_b;
            ALU_AND: val = x_a & x_b;
            ALU_OR:  val = x_a | x_b;
            ALU_XOR: val = x_a ^ x_b;
            ALU_NOT: val = ~x_a;
            ALU_MOV: val = x_a;
            ALU_INC: val = x_b + WORD_W'(1);
            ALU_DEC: val = x_b - WORD_W'(1);
            default: val = x_a;
          endcase
        end
        OP_PRELOAD, OP_NOP: ;
        default: ;
      endcase
    end
    zero_next = setz ? (val == '0) : zero_bit;
    finished  = ({1'b0, pc_next} >= program_length);
  end

  // Operand read with forwarding of the write that retires in this cycle.
  always_comb begin
    rd_a = rf[head_uop.ra];
    rd_b = rf[head_uop.rb];
    if (x_done && wr && (x_uop.rd == head_uop.ra)) begin
      rd_a = val;
    end
    if (x_done && wr && (x_uop.rd == head_uop.rb)) begin
      rd_b = val;
    end
  end

  // Control state of the execute stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid  <= 1'b0;
      state    <= ST_EXEC;
      m_tvalid <= 1'b0;
      pc       <= '0;
      zero_bit <= 1'b0;
    end else begin
      state <= state_next;
      if (x_load) begin
        x_valid <= 1'b1;
      end else if (x_done) begin
        x_valid <= 1'b0;
      end
      if (x_done) begin
        m_tvalid <= 1'b1;
        pc       <= pc_next;
        zero_bit <= zero_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Operands and operation of the execute stage.
  always_ff @(posedge clk) begin
    if (x_load) begin
      x_uop <= head_uop;
      x_a   <= rd_a;
      x_b   <= rd_b;
    end
  end

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf[i] <= '0;
      end
    end else if (x_done && wr) begin
      rf[x_uop.rd] <= val;
    end
  end

  // Data memory with registered read.
  always_ff @(posedge clk) begin
    if (x_done && mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_rd_en) begin
      mem_rdata  <= mem[x_a[DATA_AW-1:0]];
      mem_rvalid <= mem_valid[x_a[DATA_AW-1:0]];
    end
  end

  // Written marks: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
    end else if (x_done && mem_we) begin
      mem_valid[mem_waddr] <= 1'b1;
    end
  end

  // Result beat.
  always_ff @(posedge clk) begin
    if (x_done) begin
      m_tdata[9:0]   <= pc_next;
      m_tdata[11:10] <= wr ? x_uop.rd : '0;
      m_tdata[27:12] <= val;
      m_tdata[28]    <= zero_next;
      m_tdata[31:29] <= '0;
      m_tuser        <= wr;
      m_tlast        <= finished;
    end
  end

endmodule

// ===== design/frcpu_checker.sv =====
// ============================================================================
// Four-register CPU execute: port checker
// Watches the ports of the execute block and is bound to its top level.
// ============================================================================
`timescale 1ns / 1ps
`include "four_register_cpu_execute_macros.svh"

module frcpu_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // A stalled result beat stays offered.
  `FRCPU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped")

  // A stalled result beat keeps its payload.
  `FRCPU_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "result payload changed while stalled")

  // Nothing is offered straight after reset.
  `FRCPU_ASSERT_ALWAYS_NEXT(a_reset_idle, rst, !m_tvalid, "result offered after reset")

  // Without a register write the index and value fields read zero.
  `FRCPU_ASSERT_NOW(a_no_write_zero, m_tvalid && !m_tuser, m_tdata[27:10] == 18'd0, "register fields set without a write")

endmodule

bind four_register_cpu_execute frcpu_checker u_frcpu_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
